// ===== src/urf_pkg.sv =====
package urf_pkg;

	// Default number of receive FIFO entries; the FIFO holds one byte less.
	localparam int FIFO_DEPTH_DEFAULT = 256;

	// Kind of request.
	typedef enum logic [1:0] {
		FUNC_READ  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_RECV  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// Register byte offsets.
	localparam logic [7:0] OFS_DATA    = 8'd0;
	localparam logic [7:0] OFS_STATUS  = 8'd4;
	localparam logic [7:0] OFS_CONTROL = 8'd8;

	// Status bit positions.
	localparam int ST_RX_READY = 0;
	localparam int ST_TX_EMPTY = 1;
	localparam int ST_OVERFLOW = 2;
	localparam int ST_RX_FULL  = 3;

	localparam logic [3:0] STATUS_RESET = 4'b0010;

	// Control bit positions.
	localparam int CT_RX_IRQ_EN = 0;
	localparam int CT_TX_IRQ_EN = 1;
	localparam int CT_RESET     = 2;

	// Distance below the FIFO size at which the almost-full flag rises.
	localparam int ALMOST_FULL_MARGIN = 4;

	// One request as captured in the input register.
	typedef struct packed {
		func_t       func;
		logic [7:0]  offset;
		logic [31:0] write_value;
		logic [7:0]  rx_byte;
	} req_t;

	// Result of one request before the popped byte is merged in.
	typedef struct packed {
		logic [31:0] read_data;
		logic        pop;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        irq;
	} res_t;

endpackage

// ===== src/urf_ram.sv =====
module urf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/urf_regs.sv =====
module urf_regs import urf_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  req_t       req,
	output res_t       res,
	output logic [7:0] pop_data
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = PW + 1;
	localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
	localparam logic [CW-1:0] FULL_MARK = CW'(FIFO_DEPTH - ALMOST_FULL_MARGIN);

	logic [PW-1:0] rptr_q, wptr_q, rptr_d, wptr_d;
	logic [3:0]    status_q, status_d;
	logic [31:0]   control_q, control_d;

	logic [PW-1:0] wptr_inc, rptr_inc;
	logic [CW-1:0] count_after;
	logic          fifo_full, fifo_empty;
	logic          ram_wr, ram_rd;

	assign wptr_inc   = (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
	assign rptr_inc   = (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
	assign fifo_full  = (wptr_inc == rptr_q);
	assign fifo_empty = (rptr_q == wptr_q);

	// Held count once a received byte has been stored.
	assign count_after = ({1'b0, wptr_inc} >= {1'b0, rptr_q})
		? ({1'b0, wptr_inc} - {1'b0, rptr_q})
		: ({1'b0, wptr_inc} + DEPTH_C - {1'b0, rptr_q});

	always_comb begin
		rptr_d    = rptr_q;
		wptr_d    = wptr_q;
		status_d  = status_q;
		control_d = control_q;
		res       = '0;
		ram_wr    = 1'b0;
		ram_rd    = 1'b0;
		case (req.func)
			FUNC_READ: begin
				case (req.offset)
					OFS_DATA: begin
						if (!fifo_empty) begin
							ram_rd                = 1'b1;
							res.pop               = 1'b1;
							rptr_d                = rptr_inc;
							status_d[ST_RX_FULL]  = 1'b0;
							if (rptr_inc == wptr_q) begin
								status_d[ST_RX_READY] = 1'b0;
							end
						end
					end
					OFS_STATUS:  res.read_data = {28'd0, status_q};
					OFS_CONTROL: res.read_data = control_q;
					default:     res.read_data = '0;
				endcase
			end
			FUNC_WRITE: begin
				case (req.offset)
					OFS_DATA: begin
						res.tx_valid          = 1'b1;
						res.tx_byte           = req.write_value[7:0];
						status_d[ST_TX_EMPTY] = 1'b1;
					end
					OFS_CONTROL: begin
						control_d           = req.write_value;
						control_d[CT_RESET] = 1'b0;
						if (req.write_value[CT_RESET]) begin
							rptr_d   = '0;
							wptr_d   = '0;
							status_d = STATUS_RESET;
						end
					end
					default: ;
				endcase
			end
			FUNC_RECV: begin
				if (fifo_full) begin
					status_d[ST_OVERFLOW] = 1'b1;
				end else begin
					ram_wr                = 1'b1;
					wptr_d                = wptr_inc;
					status_d[ST_RX_READY] = 1'b1;
					if (count_after > FULL_MARK) begin
						status_d[ST_RX_FULL] = 1'b1;
					end
				end
			end
			default: ;
		endcase
		res.irq = (control_d[CT_RX_IRQ_EN] & status_d[ST_RX_READY])
			| (control_d[CT_TX_IRQ_EN] & status_d[ST_TX_EMPTY]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q    <= '0;
			wptr_q    <= '0;
			status_q  <= STATUS_RESET;
			control_q <= '0;
		end else if (go) begin
			rptr_q    <= rptr_d;
			wptr_q    <= wptr_d;
			status_q  <= status_d;
			control_q <= control_d;
		end
	end

	urf_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_rx_ram (
		.clk     (clk),
		.wr_en   (go & ram_wr),
		.wr_addr (wptr_q),
		.wr_data (req.rx_byte),
		.rd_en   (go & ram_rd),
		.rd_addr (rptr_q),
		.rd_data (pop_data)
	);

endmodule

// ===== src/uart_rx_fifo_registers_top.sv =====
// Register front end of a simple UART with a receive FIFO.
// The request channel (in_valid, in_stall) carries one request per accepted
// cycle: a bus read, a bus write, or a byte received from the serial line,
// selected by func. The result channel (out_valid, out_stall) returns exactly
// one result per request, in order: read data, a transmit byte with its
// valid flag, and the interrupt level as it stands after the request.
// A request is held in an input register; the register file and FIFO are
// updated when it moves into the result register, and the FIFO memory is
// read at that same edge, so the popped byte appears with the result.
// A request passes through the input register and then the result register,
// where its result can be taken; the block takes one request per cycle when
// the receiver does not stall.
// When the receiver stalls, the result register holds, one further request
// can wait in the input register, and in_stall then rises.
// Reset empties both pipeline stages, clears the FIFO pointers and the
// control word, and sets the status to transmitter empty only. The FIFO
// memory itself is not cleared; only written entries are ever read.
module uart_rx_fifo_registers_top import urf_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  offset,
	input  logic [31:0] write_value,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        irq
);

	logic       valid_s1, valid_s2;
	req_t       req_s1;
	res_t       res_d, res_s2;
	logic [7:0] pop_data;
	logic       advance;

	// The input request moves on whenever the result register is free or
	// being emptied this cycle.
	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid & ~in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (~out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (in_valid & ~in_stall) begin
			req_s1.func        <= func_t'(func);
			req_s1.offset      <= offset;
			req_s1.write_value <= write_value;
			req_s1.rx_byte     <= rx_byte;
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	urf_regs #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (advance),
		.req      (req_s1),
		.res      (res_d),
		.pop_data (pop_data)
	);

	// The memory's read register only changes on a pop, which always moves
	// a new result into the result register, so it stays aligned under stall.
	assign out_valid = valid_s2;
	assign read_data = res_s2.pop ? {24'd0, pop_data} : res_s2.read_data;
	assign tx_valid  = res_s2.tx_valid;
	assign tx_byte   = res_s2.tx_byte;
	assign irq       = res_s2.irq;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	import urf_pkg::*;

	// The FIFO inside the block holds one entry less than its depth.
	localparam int DEPTH = FIFO_DEPTH_DEFAULT;

	// Cycles with no request and no result accepted before the run is abandoned.
	// The one long receiver hold-off (HOLD_CYCLES) and the longest sender gap are
	// both far shorter, so this leaves a wide margin over the slowest correct run.
	localparam int WATCHDOG_LIMIT = 3000;

	// Result count at which the receiver holds off for a long stretch.
	localparam int HOLD_AT_RESULT = 300;
	localparam int HOLD_CYCLES = 400;

	// Number of random requests that do real work. Ignored ones do not count.
	localparam int RANDOM_REQUESTS = 1250;

	// One result as the block should present it.
	typedef struct packed {
		logic [31:0] read_data;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        irq;
	} uart_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = FUNC_NONE;
	logic [7:0]  offset = '0;
	logic [31:0] write_value = '0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_data;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        irq;

	uart_rx_fifo_registers_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.offset      (offset),
		.write_value (write_value),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.tx_valid    (tx_valid),
		.tx_byte     (tx_byte),
		.irq         (irq)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Requests waiting to be offered, and results the block still owes us.
	req_t        request_queue[$];
	uart_reply_t expected_replies[$];

	// Shadow copy of the register file and the receive FIFO.
	logic [7:0]  rx_shadow [DEPTH];
	int          shadow_rd;
	int          shadow_wr;
	logic [3:0]  shadow_status;
	logic [31:0] shadow_control;

	// Run statistics.
	int requests_planned;
	int requests_accepted;
	int results_seen;
	int mismatch_count;
	int drops_seen;
	int almost_full_seen;
	int fifo_resets_seen;
	int quiet_cycles;
	logic timed_out = 1'b0;

	// Pacing state for both sides. A calm counter gives a run of requests or
	// results with no idling at all.
	int   gap_left;
	int   in_calm;
	int   stall_left;
	int   out_calm;
	logic hold_done;
	req_t active_req;

	// Applies one request to the shadow state and returns the result the block
	// must give for it. The interrupt level is taken after the update.
	function automatic uart_reply_t uart_register_update(req_t r);
		uart_reply_t reply;
		int next_wr;
		int held;
		reply = '0;
		case (r.func)
			FUNC_READ: begin
				if (r.offset == OFS_DATA) begin
					// A read of an empty FIFO returns zero and leaves the flags alone.
					if (shadow_rd != shadow_wr) begin
						reply.read_data = {24'd0, rx_shadow[shadow_rd]};
						shadow_rd = (shadow_rd + 1) % DEPTH;
						if (shadow_rd == shadow_wr)
							shadow_status[ST_RX_READY] = 1'b0;
						shadow_status[ST_RX_FULL] = 1'b0;
					end
				end else if (r.offset == OFS_STATUS) begin
					reply.read_data = {28'd0, shadow_status};
				end else if (r.offset == OFS_CONTROL) begin
					reply.read_data = shadow_control;
				end
			end
			FUNC_WRITE: begin
				if (r.offset == OFS_DATA) begin
					reply.tx_valid = 1'b1;
					reply.tx_byte = r.write_value[7:0];
					shadow_status[ST_TX_EMPTY] = 1'b1;
				end else if (r.offset == OFS_CONTROL) begin
					shadow_control = r.write_value;
					// The reset bit empties the FIFO, restores the status and does
					// not stay set in the stored word.
					if (r.write_value[CT_RESET]) begin
						shadow_rd = 0;
						shadow_wr = 0;
						shadow_status = STATUS_RESET;
						shadow_control[CT_RESET] = 1'b0;
						fifo_resets_seen++;
					end
				end
			end
			FUNC_RECV: begin
				next_wr = (shadow_wr + 1) % DEPTH;
				if (next_wr == shadow_rd) begin
					// Full: the byte is lost and the overflow flag sticks.
					shadow_status[ST_OVERFLOW] = 1'b1;
					drops_seen++;
				end else begin
					rx_shadow[shadow_wr] = r.rx_byte;
					shadow_wr = next_wr;
					shadow_status[ST_RX_READY] = 1'b1;
					held = (shadow_wr + DEPTH - shadow_rd) % DEPTH;
					if (held > DEPTH - ALMOST_FULL_MARGIN) begin
						shadow_status[ST_RX_FULL] = 1'b1;
						almost_full_seen++;
					end
				end
			end
			default: ;
		endcase
		reply.irq = (shadow_control[CT_RX_IRQ_EN] && shadow_status[ST_RX_READY]) ||
			(shadow_control[CT_TX_IRQ_EN] && shadow_status[ST_TX_EMPTY]);
		return reply;
	endfunction

	// Queues one request. Only requests that touch a real register or the FIFO
	// count toward the size of the random part.
	function automatic void add_request(func_t f, logic [7:0] ofs, logic [31:0] wv,
		logic [7:0] rb);
		req_t r;
		r.func = f;
		r.offset = ofs;
		r.write_value = wv;
		r.rx_byte = rb;
		request_queue.push_back(r);
		if (f == FUNC_RECV ||
			(f == FUNC_READ &&
				(ofs == OFS_DATA || ofs == OFS_STATUS || ofs == OFS_CONTROL)) ||
			(f == FUNC_WRITE && (ofs == OFS_DATA || ofs == OFS_CONTROL)))
			requests_planned++;
	endfunction

	// Length of the next idle stretch: mostly none or short, now and then long.
	function automatic int pick_pause(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r == 0) begin
			calm = $urandom_range(30, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] rand_word();
		return $urandom();
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Request driver. A new request is loaded only when the current one has
	// been taken or none is offered, so a stalled payload never changes.
	// The accepted request is run through the shadow model at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_NONE;
			offset <= '0;
			write_value <= '0;
			rx_byte <= '0;
			gap_left = 0;
			in_calm = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_replies.push_back(uart_register_update(active_req));
				requests_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (request_queue.size() > 0) begin
					active_req = request_queue.pop_front();
					in_valid <= 1'b1;
					func <= active_req.func;
					offset <= active_req.offset;
					write_value <= active_req.write_value;
					rx_byte <= active_req.rx_byte;
					gap_left = pick_pause(in_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver pacing. Each taken result is compared with
	// the oldest expected one. Once, after a few hundred results, the receiver
	// holds off long enough for the block to fill and stall the sender.
	always @(posedge clk or negedge arst_n) begin
		uart_reply_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			out_calm = 0;
			hold_done = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_replies.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"tb: result %0d arrived with nothing outstanding: ",
							"rd=%h txv=%b txb=%h irq=%b"},
							results_seen, read_data, tx_valid, tx_byte, irq);
				end else begin
					want = expected_replies.pop_front();
					if (read_data !== want.read_data || tx_valid !== want.tx_valid ||
						tx_byte !== want.tx_byte || irq !== want.irq) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"tb: result %0d mismatch: ",
								"expected rd=%h txv=%b txb=%h irq=%b, ",
								"got rd=%h txv=%b txb=%h irq=%b"},
								results_seen, want.read_data, want.tx_valid,
								want.tx_byte, want.irq,
								read_data, tx_valid, tx_byte, irq);
					end
				end
				if (!hold_done && results_seen == HOLD_AT_RESULT) begin
					hold_done = 1'b1;
					stall_left = HOLD_CYCLES;
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_pause(out_calm);
			end
		end
	end

	// Watchdog: cycles in a row in which neither side moves anything.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT)
			timed_out <= 1'b1;
	end

	initial begin
		int kind;
		int len;
		int i;
		logic [31:0] ctl;
		logic [7:0] ofs;

		shadow_rd = 0;
		shadow_wr = 0;
		shadow_status = STATUS_RESET;
		shadow_control = '0;
		foreach (rx_shadow[k])
			rx_shadow[k] = '0;

		// Directed part. Reads of every register on an empty FIFO, writes that
		// the block must ignore, transmit bytes at both extremes, interrupt
		// enables, the unused request kind, a control write with every bit set
		// (the reset bit must read back clear) and a reset with bytes held.
		add_request(FUNC_READ, OFS_STATUS, rand_word(), rand_byte());
		add_request(FUNC_READ, OFS_CONTROL, rand_word(), rand_byte());
		add_request(FUNC_READ, OFS_DATA, rand_word(), rand_byte());
		add_request(FUNC_READ, 8'hFF, rand_word(), rand_byte());
		add_request(FUNC_WRITE, OFS_STATUS, 32'hFFFF_FFFF, rand_byte());
		add_request(FUNC_WRITE, 8'd12, 32'hFFFF_FFFF, rand_byte());
		add_request(FUNC_READ, OFS_STATUS, rand_word(), rand_byte());
		add_request(FUNC_WRITE, OFS_DATA, 32'h0000_0000, rand_byte());
		add_request(FUNC_WRITE, OFS_DATA, 32'hFFFF_FFFF, rand_byte());
		add_request(FUNC_WRITE, OFS_CONTROL, 32'h0000_0001, rand_byte());
		add_request(FUNC_RECV, rand_byte(), rand_word(), 8'h00);
		add_request(FUNC_RECV, rand_byte(), rand_word(), 8'hFF);
		add_request(FUNC_READ, OFS_STATUS, rand_word(), rand_byte());
		add_request(FUNC_READ, OFS_DATA, rand_word(), rand_byte());
		add_request(FUNC_READ, OFS_DATA, rand_word(), rand_byte());
		add_request(FUNC_READ, OFS_DATA, rand_word(), rand_byte());
		add_request(FUNC_NONE, rand_byte(), rand_word(), rand_byte());
		add_request(FUNC_WRITE, OFS_CONTROL, 32'hFFFF_FFFF, rand_byte());
		add_request(FUNC_READ, OFS_CONTROL, rand_word(), rand_byte());
		add_request(FUNC_RECV, rand_byte(), rand_word(), 8'hA5);
		add_request(FUNC_WRITE, OFS_CONTROL, 32'h0000_0006, rand_byte());
		add_request(FUNC_READ, OFS_DATA, rand_word(), rand_byte());
		add_request(FUNC_READ, OFS_STATUS, rand_word(), rand_byte());
		add_request(FUNC_WRITE, OFS_CONTROL, 32'h0000_0000, rand_byte());
		add_request(FUNC_READ, OFS_CONTROL, rand_word(), rand_byte());

		// Random part, built from bursts. Long receive bursts push the FIFO
		// through almost-full into overflow, long read bursts drain it again,
		// and the rest mixes control writes, transmit bytes and noise.
		requests_planned = 0;
		while (requests_planned < RANDOM_REQUESTS) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				len = ($urandom_range(0, 5) == 0) ? $urandom_range(250, 270) :
					$urandom_range(1, 20);
				for (i = 0; i < len; i++) begin
					if ($urandom_range(0, 9) == 0)
						add_request(FUNC_READ, OFS_STATUS, rand_word(), rand_byte());
					add_request(FUNC_RECV, rand_byte(), rand_word(), rand_byte());
				end
			end else if (kind < 65) begin
				len = ($urandom_range(0, 5) == 0) ? $urandom_range(250, 270) :
					$urandom_range(1, 30);
				for (i = 0; i < len; i++) begin
					if ($urandom_range(0, 9) == 0)
						add_request(FUNC_READ, OFS_STATUS, rand_word(), rand_byte());
					add_request(FUNC_READ, OFS_DATA, rand_word(), rand_byte());
				end
			end else if (kind < 75) begin
				ctl = rand_word();
				// Most control writes only change the enables; some also reset.
				ctl[CT_RESET] = ($urandom_range(0, 3) == 0);
				add_request(FUNC_WRITE, OFS_CONTROL, ctl, rand_byte());
				add_request(FUNC_READ, OFS_CONTROL, rand_word(), rand_byte());
			end else if (kind < 85) begin
				len = $urandom_range(1, 5);
				for (i = 0; i < len; i++)
					add_request(FUNC_WRITE, OFS_DATA, rand_word(), rand_byte());
			end else begin
				// Noise: any request kind, often at an unused offset.
				case ($urandom_range(0, 3))
					0: ofs = OFS_DATA;
					1: ofs = OFS_STATUS;
					2: ofs = OFS_CONTROL;
					default: ofs = rand_byte();
				endcase
				add_request(func_t'($urandom_range(0, 3)), ofs, rand_word(), rand_byte());
			end
		end

		// Reset is held from time zero and released at a clock edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every request is in and every result has come back, or
		// the watchdog fires. Checks run on the falling edge, away from the
		// clocked processes.
		while (!timed_out && !(request_queue.size() == 0 && !in_valid &&
			expected_replies.size() == 0))
			@(negedge clk);
		if (!timed_out)
			repeat (10) @(negedge clk);

		if (timed_out)
			$display("tb: watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
		if (expected_replies.size() != 0) begin
			mismatch_count++;
			$display("tb: %0d results never arrived", expected_replies.size());
		end

		$display("tb: %0d requests and %0d results checked",
			requests_accepted, results_seen);
		$display({"tb: %0d bytes dropped on overflow, %0d almost-full receives, ",
			"%0d FIFO resets, %0d mismatching results"},
			drops_seen, almost_full_seen, fifo_resets_seen, mismatch_count);
		if (!timed_out && mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== uart_rx_fifo_registers_top.f =====
src/urf_pkg.sv
src/urf_ram.sv
src/urf_regs.sv
src/uart_rx_fifo_registers_top.sv
tb/tb_top.sv
